FILE: rtl/hcmr_pkg.sv
// ----------------------------------------------------------------------------
// hcmr_pkg
// Sizes, widths and the slot layout of the hash collision match reporter.
// ----------------------------------------------------------------------------
package hcmr_pkg;

  localparam int TABLE_LOG2  = 14;
  localparam int BUCKET_BITS = 8;
  localparam int GUARD_SLOTS = 16;
  localparam int MAX_RUN     = 64;

  localparam int STORE_DEPTH = (1 << TABLE_LOG2) + GUARD_SLOTS;
  // memory address, and a slot index that can also hold the end of the table
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int IDX_W  = $clog2(STORE_DEPTH + 1);
  localparam int RUN_W  = $clog2(MAX_RUN + 1);

  localparam int VALUE_W = 64;
  localparam int TAG_W   = 32;
  localparam int CFG_W   = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(14);

  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [TAG_W-1:0]   tag;
  } slot_t;

endpackage

FILE: rtl/hash_collision_match_reporter.sv
// ----------------------------------------------------------------------------
// hash_collision_match_reporter
// Open hash table with linear probing that reports equal values per bucket.
// ----------------------------------------------------------------------------
// An insert is taken when start is high and busy is low. The start slot is
// read in the accept cycle, then one slot is examined per clock, the probe
// loop on the single read port of the slot memory setting the pace; an
// insert of zero starts no probe. Results come one per clock at most, each
// on the result ports for one cycle under result_strobe, and must be taken
// as they come. A clear command, and reset, run a clearing pass over all
// 16400 slots, one slot per clock, during which busy stays high; table_log2
// may be written at any time.
module hash_collision_match_reporter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [hcmr_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic signed [63:0]          entry_value,
  input  logic [31:0]                 entry_tag,
  output logic                        result_strobe,
  output logic                        match_valid,
  output logic [31:0]                 stored_tag,
  output logic [31:0]                 new_tag,
  output logic signed [63:0]          match_value,
  output logic                        overflow,
  output logic                        last
);
  import hcmr_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_PROBE} state_t;

  state_t             state;
  logic [CFG_W-1:0]   table_log2;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   end_idx;
  logic [RUN_W-1:0]   run;
  logic [VALUE_W-1:0] cur_value;
  logic [TAG_W-1:0]   cur_tag;
  logic               pend_valid;
  logic [TAG_W-1:0]   pend_tag;

  slot_t              slot_mem [STORE_DEPTH];
  slot_t              rd_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  wr_addr;
  slot_t              wr_data;
  logic               mem_re;
  logic [ADDR_W-1:0]  rd_addr;

  logic [CFG_W-1:0]   lg_eff;
  logic [IDX_W-1:0]   size;
  logic [IDX_W-1:0]   start_idx;
  logic [IDX_W-1:0]   idx_inc;
  logic               accept_ins;
  logic               at_end;
  logic               slot_empty;
  logic               run_full;
  logic               slot_match;
  logic               finish;
  logic               finish_ovf;

  assign busy = (state != ST_IDLE);

  // start slot and table end from the saturated table size
  always_comb begin
    lg_eff     = (32'(table_log2) > TABLE_LOG2) ? CFG_W'(TABLE_LOG2) : table_log2;
    size       = IDX_W'(1) << lg_eff;
    start_idx  = IDX_W'(entry_value[BUCKET_BITS +: TABLE_LOG2]) & (size - IDX_W'(1));
    idx_inc    = idx + IDX_W'(1);
    accept_ins = (state == ST_IDLE) && start && (command == CMD_INSERT) &&
                 (entry_value != '0);
  end

  // the shared compare on the slot just read
  always_comb begin
    at_end     = (idx >= end_idx);
    slot_empty = (rd_q.value == '0);
    run_full   = (run >= RUN_W'(MAX_RUN));
    slot_match = (rd_q.value == cur_value);
    finish     = (state == ST_PROBE) && (at_end || slot_empty || run_full);
    finish_ovf = at_end || (!slot_empty && run_full);
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = clr_cnt;
    wr_data = '0;
    mem_re  = 1'b0;
    rd_addr = start_idx[ADDR_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_re = accept_ins;
      end
      ST_PROBE: begin
        if (!at_end && slot_empty) begin
          mem_we        = 1'b1;
          wr_addr       = idx[ADDR_W-1:0];
          wr_data.value = cur_value;
          wr_data.tag   = cur_tag;
        end
        // fetch the next slot while this one is examined
        rd_addr = idx_inc[ADDR_W-1:0];
        mem_re  = (idx_inc < IDX_W'(STORE_DEPTH));
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_log2 <= CFG_RESET;
    end else if (cfg_we) begin
      table_log2 <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (clr_cnt == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
          clr_cnt <= clr_cnt + ADDR_W'(1);
        end
        ST_IDLE: begin
          pend_valid <= 1'b0;
          if (start) begin
            if (command == CMD_CLEAR) begin
              state   <= ST_CLEAR;
              clr_cnt <= '0;
            end else if (accept_ins) begin
              state     <= ST_PROBE;
              idx       <= start_idx;
              end_idx   <= size + IDX_W'(GUARD_SLOTS);
              run       <= '0;
              cur_value <= entry_value;
              cur_tag   <= entry_tag;
            end
          end
        end
        ST_PROBE: begin
          if (finish) begin
            state      <= ST_IDLE;
            pend_valid <= 1'b0;
            if (pend_valid || finish_ovf) begin
              result_strobe <= 1'b1;
              match_valid   <= pend_valid;
              stored_tag    <= pend_valid ? pend_tag : '0;
              new_tag       <= cur_tag;
              match_value   <= cur_value;
              overflow      <= finish_ovf;
              last          <= 1'b1;
            end
          end else begin
            // a match is held back one step so the final one can carry last
            if (slot_match) begin
              if (pend_valid) begin
                result_strobe <= 1'b1;
                match_valid   <= 1'b1;
                stored_tag    <= pend_tag;
                new_tag       <= cur_tag;
                match_value   <= cur_value;
                overflow      <= 1'b0;
                last          <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_tag   <= rd_q.tag;
            end
            idx <= idx_inc;
            run <= run + RUN_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_strobe_from_probe: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == ST_PROBE))
    else $error("result transfer outside a probe run");

  a_overflow_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && overflow) |-> last)
    else $error("overflow flagged on a result that is not the last");

  a_nomatch_is_overflow: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !match_valid) |-> (overflow && last))
    else $error("empty result without overflow");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (run <= RUN_W'(MAX_RUN)))
    else $error("probe run beyond limit");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last) |-> (state == ST_IDLE))
    else $error("probe still running after the final result");

endmodule

FILE: sim/tb_hash_collision_match_reporter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_collision_match_reporter
// Self-checking bench for the hash collision match reporter. Inserts and
// clears are driven under random gaps across table sizes from tiny to full;
// a scoreboard keeps its own copy of the probe table and checks every
// reported match and overflow in order.
// ----------------------------------------------------------------------------
module tb_hash_collision_match_reporter;
  import hcmr_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int DRAIN_CYCLES   = 100;

  typedef struct {
    logic               match_valid;
    logic [TAG_W-1:0]   stored_tag;
    logic [TAG_W-1:0]   new_tag;
    logic [VALUE_W-1:0] match_value;
    logic               overflow;
    logic               last;
  } match_report_t;

  class collision_scoreboard;
    logic [VALUE_W-1:0] slot_val [STORE_DEPTH];
    logic [TAG_W-1:0]   slot_tag [STORE_DEPTH];
    logic [CFG_W-1:0]   tbl_log2;
    match_report_t      expected_reports[$];
    int                 errors;

    function new();
      tbl_log2 = CFG_RESET;
      errors   = 0;
      wipe_table();
    endfunction

    function void wipe_table();
      foreach (slot_val[i]) begin
        slot_val[i] = '0;
        slot_tag[i] = '0;
      end
    endfunction

    function void set_table_log2(logic [CFG_W-1:0] v);
      tbl_log2 = v;
    endfunction

    // walks the probe run of an accepted insert and queues the reports it causes
    function void note_item(logic cmd, logic [VALUE_W-1:0] value, logic [TAG_W-1:0] tag);
      int unsigned   lg;
      int unsigned   stop;
      int unsigned   idx;
      int unsigned   run;
      bit            ovf;
      match_report_t found[$];
      match_report_t r;
      if (cmd == CMD_CLEAR) begin
        wipe_table();
        return;
      end
      if (value == '0) return;
      lg   = (tbl_log2 > TABLE_LOG2) ? TABLE_LOG2 : tbl_log2;
      stop = (1 << lg) + GUARD_SLOTS;
      idx  = int'((value >> BUCKET_BITS) & ((64'd1 << lg) - 64'd1));
      run  = 0;
      ovf  = 1'b0;
      forever begin
        if (idx >= stop) begin
          ovf = 1'b1;
          break;
        end
        if (slot_val[idx] == '0) begin
          slot_val[idx] = value;
          slot_tag[idx] = tag;
          break;
        end
        if (run >= MAX_RUN) begin
          ovf = 1'b1;
          break;
        end
        if (slot_val[idx] == value) begin
          r = '{1'b1, slot_tag[idx], tag, value, 1'b0, 1'b0};
          found.push_back(r);
        end
        idx++;
        run++;
      end
      if (found.size() == 0) begin
        if (!ovf) return;
        r = '{1'b0, '0, tag, value, 1'b1, 1'b1};
        found.push_back(r);
      end else begin
        found[found.size()-1].overflow = ovf;
        found[found.size()-1].last     = 1'b1;
      end
      foreach (found[i]) expected_reports.push_back(found[i]);
    endfunction

    function void check_report(match_report_t got);
      match_report_t want;
      if (expected_reports.size() == 0) begin
        $error("result with nothing expected: value %h new_tag %h", got.match_value,
               got.new_tag);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.match_valid !== want.match_valid) begin
        $error("match_valid: expected %0d, got %0d", want.match_valid, got.match_valid);
        errors++;
      end
      if (got.stored_tag !== want.stored_tag) begin
        $error("stored_tag: expected %h, got %h", want.stored_tag, got.stored_tag);
        errors++;
      end
      if (got.new_tag !== want.new_tag) begin
        $error("new_tag: expected %h, got %h", want.new_tag, got.new_tag);
        errors++;
      end
      if (got.match_value !== want.match_value) begin
        $error("match_value: expected %h, got %h", want.match_value, got.match_value);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                start;
  logic                busy;
  logic                command;
  logic signed [63:0]  entry_value;
  logic [31:0]         entry_tag;
  logic                result_strobe;
  logic                match_valid;
  logic [31:0]         stored_tag;
  logic [31:0]         new_tag;
  logic signed [63:0]  match_value;
  logic                overflow;
  logic                last;

  collision_scoreboard sb;
  int                  idle_cycles = 0;

  hash_collision_match_reporter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .entry_value  (entry_value),
    .entry_tag    (entry_tag),
    .result_strobe(result_strobe),
    .match_valid  (match_valid),
    .stored_tag   (stored_tag),
    .new_tag      (new_tag),
    .match_value  (match_value),
    .overflow     (overflow),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // results are checked before the input transfer of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe === 1'b1) begin
        sb.check_report(match_report_t'{match_valid, stored_tag, new_tag, match_value,
                                        overflow, last});
      end
      if (start && busy === 1'b0) sb.note_item(command, entry_value, entry_tag);
      if (cfg_we) sb.set_table_log2(cfg_wdata);
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || result_strobe === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(logic cmd, logic [63:0] value, logic [31:0] tag, int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       = 1'b1;
    command     = cmd;
    entry_value = value;
    entry_tag   = tag;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // all reports in, block no longer busy, then room for a silent probe to finish
  task automatic wait_for_idle(int extra);
    start = 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_table_log2(logic [CFG_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // one table size: clear, then inserts clustered round a hot slot so that
  // runs grow, values repeat and overflow is reached; a little noise mixed in
  task automatic run_phase(logic [CFG_W-1:0] lg_cfg, int n_items, bit deep);
    int          lg_eff;
    int          span;
    int          hot_base;
    int          roll;
    bit          calm;
    logic [63:0] v;
    logic [63:0] pool[$];
    wait_for_idle(SETTLE_CYCLES);
    write_table_log2(lg_cfg);
    lg_eff = (lg_cfg > TABLE_LOG2) ? TABLE_LOG2 : lg_cfg;
    span   = 1 << lg_eff;
    if (deep) hot_base = $urandom_range(0, span / 4);
    else if (lg_eff <= 5) hot_base = (span > 4) ? span - $urandom_range(1, 4) : 0;
    else hot_base = $urandom_range(0, span - 1);
    calm = ($urandom_range(0, 3) == 0);
    send_item(CMD_CLEAR, {$urandom, $urandom}, $urandom, draw_gap(calm));
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 2 && !deep) begin
        send_item(CMD_CLEAR, {$urandom, $urandom}, $urandom, draw_gap(calm));
        pool.delete();
      end else begin
        if (roll < 4) begin
          v = '0;
        end else if (roll < 10 && !deep) begin
          v = {$urandom, $urandom};
        end else if (roll < 45 && pool.size() > 0) begin
          v = pool[$urandom_range(0, pool.size() - 1)];
        end else begin
          v = {$urandom, $urandom};
          v[BUCKET_BITS +: TABLE_LOG2] = TABLE_LOG2'(hot_base + (deep ? 0 : $urandom_range(0, 3)));
        end
        send_item(CMD_INSERT, v, $urandom, draw_gap(calm));
        if (v != '0) pool.push_back(v);
      end
    end
  endtask

  int lg_seq[16] = '{4, 14, 9, 15, 1, 7, 12, 5, 10, 2, 13, 6, 3, 11, 8, 0};

  initial begin
    sb          = new();
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    start       = 1'b0;
    command     = CMD_INSERT;
    entry_value = '0;
    entry_tag   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // extremes at full size: largest and smallest values, repeats, zero ignored
    send_item(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, draw_gap(1'b0));
    send_item(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h0000_0000, draw_gap(1'b0));
    send_item(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0001, draw_gap(1'b0));
    send_item(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0002, draw_gap(1'b0));
    send_item(CMD_INSERT, 64'h0, 32'h1234_5678, draw_gap(1'b0));
    send_item(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_A5A5, draw_gap(1'b0));
    send_item(CMD_INSERT, 64'h1, 32'h5A5A_5A5A, draw_gap(1'b0));
    send_item(CMD_CLEAR, 64'hDEAD_BEEF_0000_0001, 32'hFFFF_FFFF, draw_gap(1'b0));
    send_item(CMD_INSERT, 64'h1, 32'h0000_0001, draw_gap(1'b0));

    // smallest table: fill to the end, then a match that also overflows,
    // then an overflow with no match
    wait_for_idle(SETTLE_CYCLES);
    write_table_log2('0);
    repeat (16) send_item(CMD_INSERT, {$urandom, $urandom | 32'h1}, $urandom, draw_gap(1'b0));
    send_item(CMD_INSERT, 64'h1, 32'hCAFE_0001, draw_gap(1'b0));
    send_item(CMD_INSERT, {$urandom, $urandom | 32'h1}, $urandom, draw_gap(1'b0));

    foreach (lg_seq[i]) begin
      if (lg_seq[i] == 9) run_phase(CFG_W'(lg_seq[i]), 90, 1'b1);
      else if (lg_seq[i] <= 5) run_phase(CFG_W'(lg_seq[i]), 20, 1'b0);
      else run_phase(CFG_W'(lg_seq[i]), 8, 1'b0);
    end

    wait_for_idle(DRAIN_CYCLES);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/hcmr_pkg.sv
rtl/hash_collision_match_reporter.sv
sim/tb_hash_collision_match_reporter.sv
